FILE: rtl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// tnc_pkg
// shared types, codes and constants of the newreno congestion window engine
// ----------------------------------------------------------------------------
`default_nettype none

package tnc_pkg;

	localparam int DATA_W = 32;
	localparam int SEG_W  = 16;
	localparam int CNT_W  = $clog2(DATA_W);

	localparam logic [DATA_W-1:0] ALL_ONES      = '1;
	localparam logic [DATA_W-1:0] RST_START_WIN = DATA_W'(14600);
	localparam logic [SEG_W-1:0]  RST_SEG_SIZE  = SEG_W'(1460);
	localparam logic [CNT_W-1:0]  MOD_LAST      = CNT_W'(DATA_W - 1);

	// event codes
	localparam logic [2:0] OP_INIT    = 3'd0;
	localparam logic [2:0] OP_ACK     = 3'd1;
	localparam logic [2:0] OP_LOSS    = 3'd2;
	localparam logic [2:0] OP_REC_END = 3'd3;
	localparam logic [2:0] OP_RESTART = 3'd4;

	// loss kinds
	localparam logic [1:0] LOSS_TIMEOUT = 2'd0;
	localparam logic [1:0] LOSS_DUPACK  = 2'd1;

	// configuration register indexes
	localparam logic REG_SEG_SIZE  = 1'b0;
	localparam logic REG_START_WIN = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic [DATA_W-1:0] sat_res;
		logic              flag;   // add: carry out, sub: borrow (a < b)
	} alu_rsp_t;

	typedef enum logic [12:0] {
		ST_IDLE      = 13'b0000000000001,
		ST_ACK_CMP   = 13'b0000000000010,
		ST_SS_MIN    = 13'b0000000000100,
		ST_SS_ADD    = 13'b0000000001000,
		ST_AV_ADD    = 13'b0000000010000,
		ST_AV_CMP    = 13'b0000000100000,
		ST_AV_GROW   = 13'b0000001000000,
		ST_MOD       = 13'b0000010000000,
		ST_LOSS_T    = 13'b0000100000000,
		ST_LOSS_TRIP = 13'b0001000000000,
		ST_LOSS_WIN  = 13'b0010000000000,
		ST_CLAMP     = 13'b0100000000000,
		ST_DONE      = 13'b1000000000000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/tnc_alu.sv
// ----------------------------------------------------------------------------
// tnc_alu
// shared 32-bit add / subtract unit with saturating sum and carry or borrow
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_alu (
	input  tnc_pkg::alu_req_t req,
	output tnc_pkg::alu_rsp_t rsp
);

	logic [tnc_pkg::DATA_W-1:0] b_op;
	logic [tnc_pkg::DATA_W:0]   sum;

	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{tnc_pkg::DATA_W{1'b0}}, req.sub};

	always_comb begin
		rsp.res     = sum[tnc_pkg::DATA_W-1:0];
		rsp.flag    = req.sub ? ~sum[tnc_pkg::DATA_W] : sum[tnc_pkg::DATA_W];
		rsp.sat_res = (!req.sub && sum[tnc_pkg::DATA_W]) ? tnc_pkg::ALL_ONES
			: sum[tnc_pkg::DATA_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/tcp_newreno_cwnd_engine.sv
// ----------------------------------------------------------------------------
// tcp_newreno_cwnd_engine
// congestion window, slow-start threshold and avoidance counter of one flow
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; busy stays high until
// the result has been shown. The result is on window_now and threshold_now for
// the single cycle in which done is high, and the receiver must take it then.
// All work goes through one shared 32-bit add/subtract unit under a sequencer,
// one use per cycle. Init, unused codes and ignored acks go straight to done;
// a duplicate-ack loss adds three segments to the new threshold; an avoidance
// ack grows the window one segment per pass, and with a zero segment size it
// takes a bit-serial remainder instead. The next event may start in the cycle
// after done.
// Configuration writes are always taken and must only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_newreno_cwnd_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [tnc_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   op,
	input  wire logic [tnc_pkg::DATA_W-1:0]   acked_count,
	input  wire logic                         recovery_took_ack,
	input  wire logic [tnc_pkg::DATA_W-1:0]   flight_bytes,
	input  wire logic [1:0]                   loss_kind,
	input  wire logic                         first_timeout,
	input  wire logic                         syn_was_resent,
	output logic                              done,
	output logic [tnc_pkg::DATA_W-1:0]        window_now,
	output logic [tnc_pkg::DATA_W-1:0]        threshold_now
);

	tnc_pkg::state_t            state_q;
	logic [tnc_pkg::SEG_W-1:0]  seg_q;
	logic [tnc_pkg::DATA_W-1:0] start_win_q;
	logic [tnc_pkg::DATA_W-1:0] window_q;
	logic [tnc_pkg::DATA_W-1:0] threshold_q;
	logic [tnc_pkg::DATA_W-1:0] avoid_q;
	logic [tnc_pkg::DATA_W-1:0] arg_q;
	logic [tnc_pkg::DATA_W-1:0] tmp_q;
	logic [1:0]                 kind_q;
	logic                       first_q;
	logic [tnc_pkg::CNT_W-1:0]  cnt_q;

	tnc_pkg::alu_req_t alu_req;
	tnc_pkg::alu_rsp_t alu_rsp;

	logic [tnc_pkg::DATA_W-1:0] seg_ext;
	logic [tnc_pkg::DATA_W-1:0] seg_dbl;
	logic [tnc_pkg::DATA_W-1:0] mod_shift;
	logic                       mod_ge;
	logic                       accept;

	assign seg_ext   = {{(tnc_pkg::DATA_W-tnc_pkg::SEG_W){1'b0}}, seg_q};
	assign seg_dbl   = {seg_ext[tnc_pkg::DATA_W-2:0], 1'b0};
	assign mod_shift = {avoid_q[tnc_pkg::DATA_W-2:0], tmp_q[tnc_pkg::DATA_W-1]};
	assign mod_ge    = avoid_q[tnc_pkg::DATA_W-1] | ~alu_rsp.flag;

	assign busy          = (state_q != tnc_pkg::ST_IDLE);
	assign accept        = start && !busy;
	assign cfg_ready     = 1'b1;
	assign done          = (state_q == tnc_pkg::ST_DONE);
	assign window_now    = window_q;
	assign threshold_now = threshold_q;

	tnc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_req = '{a: window_q, b: threshold_q, sub: 1'b1};
		unique case (state_q)
			tnc_pkg::ST_ACK_CMP:   alu_req = '{a: window_q, b: threshold_q, sub: 1'b1};
			tnc_pkg::ST_SS_MIN:    alu_req = '{a: arg_q, b: seg_ext, sub: 1'b1};
			tnc_pkg::ST_SS_ADD:    alu_req = '{a: window_q, b: tmp_q, sub: 1'b0};
			tnc_pkg::ST_AV_ADD:    alu_req = '{a: avoid_q, b: arg_q, sub: 1'b0};
			tnc_pkg::ST_AV_CMP:    alu_req = '{a: avoid_q, b: window_q, sub: 1'b1};
			tnc_pkg::ST_AV_GROW:   alu_req = '{a: window_q, b: seg_ext, sub: 1'b0};
			tnc_pkg::ST_MOD:       alu_req = '{a: mod_shift, b: window_q, sub: 1'b1};
			tnc_pkg::ST_LOSS_T:    alu_req = '{a: {1'b0, arg_q[tnc_pkg::DATA_W-1:1]},
				b: seg_dbl, sub: 1'b1};
			tnc_pkg::ST_LOSS_TRIP: alu_req = '{a: seg_dbl, b: seg_ext, sub: 1'b0};
			tnc_pkg::ST_LOSS_WIN:  alu_req = '{a: tmp_q, b: arg_q, sub: 1'b0};
			tnc_pkg::ST_CLAMP:     alu_req = '{a: arg_q, b: window_q, sub: 1'b1};
			default:               alu_req = '{a: window_q, b: threshold_q, sub: 1'b1};
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= tnc_pkg::RST_SEG_SIZE;
			start_win_q <= tnc_pkg::RST_START_WIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tnc_pkg::REG_SEG_SIZE:  seg_q       <= cfg_data[tnc_pkg::SEG_W-1:0];
				tnc_pkg::REG_START_WIN: start_win_q <= cfg_data;
				default:                ;
			endcase
		end
	end

	// operands of the current transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= loss_kind;
			first_q <= first_timeout;
			unique case (op)
				tnc_pkg::OP_LOSS:    arg_q <= flight_bytes;
				tnc_pkg::OP_REC_END: arg_q <= threshold_q;
				tnc_pkg::OP_RESTART: arg_q <= start_win_q;
				default:             arg_q <= acked_count;
			endcase
		end else if (state_q == tnc_pkg::ST_LOSS_TRIP) begin
			arg_q <= alu_rsp.res;
		end
	end

	// sequencer and flow state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tnc_pkg::ST_IDLE;
			window_q    <= tnc_pkg::RST_START_WIN;
			threshold_q <= tnc_pkg::ALL_ONES;
			avoid_q     <= '0;
			tmp_q       <= '0;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				tnc_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (op)
							tnc_pkg::OP_INIT: begin
								window_q    <= syn_was_resent ? seg_ext : start_win_q;
								threshold_q <= tnc_pkg::ALL_ONES;
								avoid_q     <= '0;
								state_q     <= tnc_pkg::ST_DONE;
							end
							tnc_pkg::OP_ACK: begin
								if (recovery_took_ack || acked_count == '0)
									state_q <= tnc_pkg::ST_DONE;
								else
									state_q <= tnc_pkg::ST_ACK_CMP;
							end
							tnc_pkg::OP_LOSS:    state_q <= tnc_pkg::ST_LOSS_T;
							tnc_pkg::OP_REC_END: state_q <= tnc_pkg::ST_CLAMP;
							tnc_pkg::OP_RESTART: state_q <= tnc_pkg::ST_CLAMP;
							default:             state_q <= tnc_pkg::ST_DONE;
						endcase
					end
				end
				tnc_pkg::ST_ACK_CMP: begin
					state_q <= alu_rsp.flag ? tnc_pkg::ST_SS_MIN : tnc_pkg::ST_AV_ADD;
				end
				tnc_pkg::ST_SS_MIN: begin
					tmp_q   <= alu_rsp.flag ? arg_q : seg_ext;
					state_q <= tnc_pkg::ST_SS_ADD;
				end
				tnc_pkg::ST_SS_ADD: begin
					window_q <= alu_rsp.sat_res;
					state_q  <= tnc_pkg::ST_DONE;
				end
				tnc_pkg::ST_AV_ADD: begin
					if (seg_q != '0) begin
						avoid_q <= alu_rsp.sat_res;
						state_q <= tnc_pkg::ST_AV_CMP;
					end else if (window_q != '0 && window_q != tnc_pkg::ALL_ONES) begin
						tmp_q   <= alu_rsp.sat_res;
						avoid_q <= '0;
						cnt_q   <= '0;
						state_q <= tnc_pkg::ST_MOD;
					end else begin
						avoid_q <= alu_rsp.sat_res;
						state_q <= tnc_pkg::ST_DONE;
					end
				end
				tnc_pkg::ST_AV_CMP: begin
					if (window_q == tnc_pkg::ALL_ONES || alu_rsp.flag) begin
						state_q <= tnc_pkg::ST_DONE;
					end else begin
						avoid_q <= alu_rsp.res;
						state_q <= tnc_pkg::ST_AV_GROW;
					end
				end
				tnc_pkg::ST_AV_GROW: begin
					window_q <= alu_rsp.sat_res;
					state_q  <= tnc_pkg::ST_AV_CMP;
				end
				tnc_pkg::ST_MOD: begin
					avoid_q <= mod_ge ? alu_rsp.res : mod_shift;
					tmp_q   <= {tmp_q[tnc_pkg::DATA_W-2:0], 1'b0};
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == tnc_pkg::MOD_LAST)
						state_q <= tnc_pkg::ST_DONE;
				end
				tnc_pkg::ST_LOSS_T: begin
					avoid_q <= '0;
					priority if (kind_q == tnc_pkg::LOSS_TIMEOUT) begin
						if (first_q)
							threshold_q <= alu_rsp.flag ? seg_dbl : alu_req.a;
						window_q <= seg_ext;
						state_q  <= tnc_pkg::ST_DONE;
					end else if (kind_q == tnc_pkg::LOSS_DUPACK) begin
						threshold_q <= alu_rsp.flag ? seg_dbl : alu_req.a;
						tmp_q       <= alu_rsp.flag ? seg_dbl : alu_req.a;
						state_q     <= tnc_pkg::ST_LOSS_TRIP;
					end else begin
						threshold_q <= alu_rsp.flag ? seg_dbl : alu_req.a;
						window_q    <= alu_rsp.flag ? seg_dbl : alu_req.a;
						state_q     <= tnc_pkg::ST_DONE;
					end
				end
				tnc_pkg::ST_LOSS_TRIP: begin
					state_q <= tnc_pkg::ST_LOSS_WIN;
				end
				tnc_pkg::ST_LOSS_WIN: begin
					window_q <= alu_rsp.sat_res;
					state_q  <= tnc_pkg::ST_DONE;
				end
				tnc_pkg::ST_CLAMP: begin
					if (alu_rsp.flag)
						window_q <= arg_q;
					avoid_q <= '0;
					state_q <= tnc_pkg::ST_DONE;
				end
				tnc_pkg::ST_DONE: begin
					state_q <= tnc_pkg::ST_IDLE;
				end
				default: begin
					state_q <= tnc_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_tcp_newreno_cwnd_engine.sv
// ----------------------------------------------------------------------------
// tb_tcp_newreno_cwnd_engine
// self-checking testbench of the newreno congestion window engine
// ----------------------------------------------------------------------------
// Events go in over the start/busy command handshake, and configuration goes
// in over its own write channel while the engine is idle. A flow tracker keeps
// its own window, threshold and avoidance count. For each accepted event it
// works out the window and threshold that should come back on the next done
// strobe, and it compares every result with the oldest pending one. A short
// directed run covers saturation, zero segment size, every loss kind and the
// spare codes. Random phases under several segment sizes and start windows
// follow, mostly ack-driven flows with losses, recovery exits and restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tcp_newreno_cwnd_engine;
	import tnc_pkg::*;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [1:0] LOSS_OTHER     = 2'd2;
	localparam logic [1:0] LOSS_SPARE     = 2'd3;
	localparam int         CYCLE_LIMIT    = 3_000_000;
	localparam int         SETTLE_CYCLES  = 48;

	typedef struct {
		logic [2:0]        op;
		logic [DATA_W-1:0] acked;
		logic              took;
		logic [DATA_W-1:0] flight;
		logic [1:0]        kind;
		logic              first;
		logic              syn;
	} cc_event_t;

	typedef struct {
		logic [DATA_W-1:0] window;
		logic [DATA_W-1:0] threshold;
	} cwnd_pair_t;

	class cwnd_tracker;
		logic [SEG_W-1:0]  seg_size;
		logic [DATA_W-1:0] start_win;
		logic [DATA_W-1:0] cwnd;
		logic [DATA_W-1:0] ssthresh;
		logic [DATA_W-1:0] avoid_bytes;
		cwnd_pair_t        pending[$];
		int                errors;

		function new();
			seg_size    = RST_SEG_SIZE;
			start_win   = RST_START_WIN;
			cwnd        = RST_START_WIN;
			ssthresh    = ALL_ONES;
			avoid_bytes = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic idx, logic [DATA_W-1:0] data);
			if (idx == REG_SEG_SIZE) begin
				seg_size = data[SEG_W-1:0];
			end else begin
				start_win = data;
			end
		endfunction

		function logic [DATA_W-1:0] sat_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			logic [DATA_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[DATA_W] ? ALL_ONES : s[DATA_W-1:0];
		endfunction

		function void grow_on_ack(logic [DATA_W-1:0] acked);
			logic [DATA_W-1:0] seg32;
			seg32 = DATA_W'(seg_size);
			if (cwnd < ssthresh) begin
				cwnd = sat_add(cwnd, (acked < seg32) ? acked : seg32);
			end else begin
				avoid_bytes = sat_add(avoid_bytes, acked);
				if (seg32 == '0) begin
					if (cwnd != '0 && cwnd != ALL_ONES)
						avoid_bytes = avoid_bytes % cwnd;
				end else begin
					while (cwnd != ALL_ONES && avoid_bytes >= cwnd) begin
						avoid_bytes = avoid_bytes - cwnd;
						cwnd        = sat_add(cwnd, seg32);
					end
				end
			end
		endfunction

		function void note_event(cc_event_t ev);
			logic [DATA_W-1:0] seg32;
			logic [DATA_W-1:0] half;
			logic [DATA_W-1:0] floor2;
			logic [DATA_W-1:0] loss_thr;
			seg32    = DATA_W'(seg_size);
			half     = ev.flight >> 1;
			floor2   = seg32 << 1;
			loss_thr = (half > floor2) ? half : floor2;
			case (ev.op)
				OP_INIT: begin
					cwnd        = ev.syn ? seg32 : start_win;
					ssthresh    = ALL_ONES;
					avoid_bytes = '0;
				end
				OP_ACK: begin
					if (!ev.took && ev.acked != '0)
						grow_on_ack(ev.acked);
				end
				OP_LOSS: begin
					if (ev.kind == LOSS_TIMEOUT) begin
						if (ev.first)
							ssthresh = loss_thr;
						cwnd = seg32;
					end else begin
						ssthresh = loss_thr;
						if (ev.kind == LOSS_DUPACK) begin
							cwnd = sat_add(loss_thr, seg32 * 32'd3);
						end else begin
							cwnd = loss_thr;
						end
					end
					avoid_bytes = '0;
				end
				OP_REC_END: begin
					if (cwnd > ssthresh)
						cwnd = ssthresh;
					avoid_bytes = '0;
				end
				OP_RESTART: begin
					if (cwnd > start_win)
						cwnd = start_win;
					avoid_bytes = '0;
				end
				default: begin
				end
			endcase
			pending.push_back('{cwnd, ssthresh});
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_window(logic [DATA_W-1:0] win, logic [DATA_W-1:0] thr);
			cwnd_pair_t exp_pair;
			if (pending.size() == 0) begin
				report($sformatf("result with no transaction pending: window %0d threshold %0d",
					win, thr));
				return;
			end
			exp_pair = pending.pop_front();
			if (win !== exp_pair.window)
				report($sformatf("window_now %0d, predicted %0d", win, exp_pair.window));
			if (thr !== exp_pair.threshold)
				report($sformatf("threshold_now %0d, predicted %0d", thr, exp_pair.threshold));
		endtask
	endclass

	logic              clk;
	logic              arst_n            = 1'b0;
	logic              cfg_valid         = 1'b0;
	logic              cfg_ready;
	logic              cfg_index         = 1'b0;
	logic [DATA_W-1:0] cfg_data          = '0;
	logic              start             = 1'b0;
	logic              busy;
	logic [2:0]        op                = OP_INIT;
	logic [DATA_W-1:0] acked_count       = '0;
	logic              recovery_took_ack = 1'b0;
	logic [DATA_W-1:0] flight_bytes      = '0;
	logic [1:0]        loss_kind         = LOSS_TIMEOUT;
	logic              first_timeout     = 1'b0;
	logic              syn_was_resent    = 1'b0;
	logic              done;
	logic [DATA_W-1:0] window_now;
	logic [DATA_W-1:0] threshold_now;

	cwnd_tracker track = new();
	int          burst_left = 0;
	int          cycle_count = 0;

	tcp_newreno_cwnd_engine u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.start             (start),
		.busy              (busy),
		.op                (op),
		.acked_count       (acked_count),
		.recovery_took_ack (recovery_took_ack),
		.flight_bytes      (flight_bytes),
		.loss_kind         (loss_kind),
		.first_timeout     (first_timeout),
		.syn_was_resent    (syn_was_resent),
		.done              (done),
		.window_now        (window_now),
		.threshold_now     (threshold_now)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tcp_newreno_cwnd_engine regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			track.check_window(window_now, threshold_now);
	end

	function automatic cc_event_t make_event(logic [2:0] ev_op, logic [DATA_W-1:0] acked,
			logic took, logic [DATA_W-1:0] flight, logic [1:0] kind, logic first, logic syn);
		cc_event_t ev;
		ev.op     = ev_op;
		ev.acked  = acked;
		ev.took   = took;
		ev.flight = flight;
		ev.kind   = kind;
		ev.first  = first;
		ev.syn    = syn;
		return ev;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(15, 40);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// acks that would spin the avoidance loop for long are kept near the window
	function automatic cc_event_t random_event();
		cc_event_t         ev;
		int                r;
		logic [DATA_W+1:0] span;
		logic [DATA_W+1:0] flight_span;
		logic              light_loop;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			ev.op = OP_INIT;
		end else if (r < 70) begin
			ev.op = OP_ACK;
		end else if (r < 82) begin
			ev.op = OP_LOSS;
		end else if (r < 89) begin
			ev.op = OP_REC_END;
		end else if (r < 96) begin
			ev.op = OP_RESTART;
		end else begin
			ev.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		span = {2'b00, track.cwnd} << 2;
		if (span > {2'b00, ALL_ONES})
			span = {2'b00, ALL_ONES};
		light_loop = (track.cwnd < track.ssthresh) || (track.seg_size == '0) ||
			(track.seg_size >= 16'd1024 && track.cwnd >= 32'd4096);
		r = $urandom_range(0, 99);
		if (r < 5) begin
			ev.acked = '0;
		end else if (r < 60) begin
			ev.acked = $urandom_range(1, 32'(track.seg_size) * 2 + 1);
		end else if (r < 90 || !light_loop) begin
			ev.acked = $urandom_range(0, span[DATA_W-1:0]);
		end else begin
			ev.acked = $urandom;
		end
		ev.took = ($urandom_range(0, 9) == 0);
		flight_span = {2'b00, track.cwnd} << 1;
		if (flight_span > {2'b00, ALL_ONES})
			flight_span = {2'b00, ALL_ONES};
		if ($urandom_range(0, 9) < 7) begin
			ev.flight = $urandom_range(0, flight_span[DATA_W-1:0]);
		end else begin
			ev.flight = $urandom;
		end
		r = $urandom_range(0, 99);
		if (r < 35) begin
			ev.kind = LOSS_TIMEOUT;
		end else if (r < 70) begin
			ev.kind = LOSS_DUPACK;
		end else if (r < 90) begin
			ev.kind = LOSS_OTHER;
		end else begin
			ev.kind = LOSS_SPARE;
		end
		ev.first = 1'($urandom_range(0, 1));
		ev.syn   = 1'($urandom_range(0, 1));
		return ev;
	endfunction

	task automatic send_event(cc_event_t ev, int gap);
		op                <= ev.op;
		acked_count       <= ev.acked;
		recovery_took_ack <= ev.took;
		flight_bytes      <= ev.flight;
		loss_kind         <= ev.kind;
		first_timeout     <= ev.first;
		syn_was_resent    <= ev.syn;
		start             <= 1'b1;
		do @(posedge clk); while (busy);
		track.note_event(ev);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (track.pending.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [SEG_W-1:0] seg, logic [DATA_W-1:0] win);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SEG_SIZE;
		cfg_data  <= DATA_W'(seg);
		do @(posedge clk); while (!cfg_ready);
		track.write_reg(REG_SEG_SIZE, DATA_W'(seg));
		cfg_index <= REG_START_WIN;
		cfg_data  <= win;
		do @(posedge clk); while (!cfg_ready);
		track.write_reg(REG_START_WIN, win);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(logic [SEG_W-1:0] seg, logic [DATA_W-1:0] win, int count);
		drain_results();
		set_config(seg, win);
		send_event(make_event(OP_INIT, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		for (int i = 0; i < count; i++) begin
			send_event(random_event(), pick_gap());
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: slow start, every loss kind, clamps, spare codes
		send_event(make_event(OP_ACK, ALL_ONES, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, 32'd1000, 1'b1, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_ACK, 32'd1, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_LOSS, '0, 1'b0, ALL_ONES, LOSS_TIMEOUT, 1'b1, 1'b0), 0);
		send_event(make_event(OP_LOSS, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_LOSS, '0, 1'b0, 32'd100000, LOSS_DUPACK, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, 32'd60000, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_REC_END, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_LOSS, '0, 1'b0, 32'd1000, LOSS_OTHER, 1'b0, 1'b0), 0);
		send_event(make_event(OP_LOSS, '0, 1'b0, 32'h1234_5678, LOSS_SPARE, 1'b1, 1'b1), 0);
		send_event(make_event(OP_RESTART, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_INIT, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b1), 0);
		send_event(make_event(OP_INIT, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_SPARE_FIRST, ALL_ONES, 1'b1, ALL_ONES, LOSS_SPARE, 1'b1, 1'b1),
			0);
		send_event(make_event(OP_SPARE_LAST, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());

		// window and avoidance count saturation
		drain_results();
		set_config(RST_SEG_SIZE, 32'hFFFF_FFF0);
		send_event(make_event(OP_INIT, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, 32'd100, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, ALL_ONES, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_ACK, ALL_ONES, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);

		// zero segment size, with and without a zero window
		drain_results();
		set_config('0, RST_START_WIN);
		send_event(make_event(OP_INIT, '0, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b1), 0);
		send_event(make_event(OP_ACK, 32'd500, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_LOSS, '0, 1'b0, 32'd1, LOSS_TIMEOUT, 1'b1, 1'b0), pick_gap());
		send_event(make_event(OP_ACK, 32'd700, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);
		send_event(make_event(OP_LOSS, '0, 1'b0, 32'd2000, LOSS_OTHER, 1'b0, 1'b0), 0);
		send_event(make_event(OP_ACK, 32'd2500, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), pick_gap());
		send_event(make_event(OP_ACK, 32'd600, 1'b0, '0, LOSS_TIMEOUT, 1'b0, 1'b0), 0);

		run_phase(RST_SEG_SIZE, RST_START_WIN, 200);
		run_phase(16'd1, 32'd1, 150);
		run_phase(16'hFFFF, ALL_ONES, 150);
		run_phase('0, 32'd3000, 60);
		run_phase(16'($urandom_range(1, 65535)), $urandom_range(1, ALL_ONES), 200);
		run_phase(16'd536, 32'd4380, 220);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (track.pending.size() != 0)
			track.report($sformatf("%0d results never arrived", track.pending.size()));
		if (track.errors == 0) begin
			$display("tcp_newreno_cwnd_engine regression: pass");
		end else begin
			$display("tcp_newreno_cwnd_engine regression: fail");
		end
		$finish;
	end

endmodule
